// ----- rtl/wavp_pkg.sv -----
package wavp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
        logic       end_of_stream;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] sample_value;
        logic               channel_index;
        logic [1:0]         channel_count;
        logic [31:0]        sample_rate;
        logic [31:0]        data_length;
        logic [3:0]         error_code;
        logic               last_result;
    } t_out_word;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_DATA   = 4'b0010,
        PH_ERROR  = 4'b0100,
        PH_DONE   = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [5:0]  byte_position;
        logic [31:0] data_bytes_seen;
        logic [31:0] field_shift;
        logic [1:0]  stored_channels;
        logic [31:0] stored_rate;
        logic [31:0] stored_length;
        logic [7:0]  low_sample_byte;
        logic        next_channel;
        t_phase      parse_phase;
    } t_state;

    localparam t_state STATE_RESET = '{
        byte_position:   6'd0,
        data_bytes_seen: 32'd0,
        field_shift:     32'd0,
        stored_channels: 2'd0,
        stored_rate:     32'd0,
        stored_length:   32'd0,
        low_sample_byte: 8'd0,
        next_channel:    1'b0,
        parse_phase:     PH_HEADER
    };

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    localparam logic [3:0] ERR_RIFF      = 4'd0;
    localparam logic [3:0] ERR_WAVE      = 4'd1;
    localparam logic [3:0] ERR_FMT       = 4'd2;
    localparam logic [3:0] ERR_NOT_PCM   = 4'd3;
    localparam logic [3:0] ERR_CHANNELS  = 4'd4;
    localparam logic [3:0] ERR_8BIT      = 4'd5;
    localparam logic [3:0] ERR_DEPTH     = 4'd6;
    localparam logic [3:0] ERR_DATA_TAG  = 4'd7;
    localparam logic [3:0] ERR_SHORT     = 4'd8;

    localparam logic [5:0] POS_RIFF     = 6'd3;
    localparam logic [5:0] POS_WAVE     = 6'd11;
    localparam logic [5:0] POS_FMT      = 6'd15;
    localparam logic [5:0] POS_FORMAT   = 6'd23;
    localparam logic [5:0] POS_RATE     = 6'd27;
    localparam logic [5:0] POS_DEPTH    = 6'd35;
    localparam logic [5:0] POS_DATA_TAG = 6'd39;
    localparam logic [5:0] POS_LENGTH   = 6'd43;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] LOW_HALF = 32'h0000_ffff;

    localparam logic [15:0] FMT_PCM    = 16'd1;
    localparam logic [15:0] CH_MONO    = 16'd1;
    localparam logic [15:0] CH_STEREO  = 16'd2;
    localparam logic [15:0] DEPTH_8    = 16'd8;
    localparam logic [15:0] DEPTH_16   = 16'd16;

    function automatic t_out_word blank_word();
        t_out_word w;
        w = '0;
        return w;
    endfunction

    function automatic t_out_word error_word(input logic [3:0] code);
        t_out_word w;
        w = '0;
        w.kind = KIND_ERROR;
        w.error_code = code;
        return w;
    endfunction

endpackage

// ----- rtl/wavp_step.sv -----
module wavp_step (
    input  wavp_pkg::t_state    i_state,
    input  wavp_pkg::t_in_word  i_word,
    output wavp_pkg::t_state    o_state,
    output wavp_pkg::t_out_word o_res [2],
    output logic [1:0]          o_res_cnt
);

    wavp_pkg::t_state    s;
    wavp_pkg::t_state    ns;
    wavp_pkg::t_out_word res [2];
    logic [1:0]          cnt;
    logic                err_hit;
    logic [3:0]          err_code;
    logic [31:0]         fs;

    always_comb begin
        s = i_word.start_of_file ? wavp_pkg::STATE_RESET : i_state;
        ns = s;
        res[0] = wavp_pkg::blank_word();
        res[1] = wavp_pkg::blank_word();
        cnt = 2'd0;
        err_hit = 1'b0;
        err_code = wavp_pkg::ERR_RIFF;
        fs = {i_word.data_byte, s.field_shift[31:8]};

        case (s.parse_phase)
            wavp_pkg::PH_HEADER: begin
                ns.field_shift = fs;
                ns.byte_position = s.byte_position + 6'd1;
                case (s.byte_position)
                    wavp_pkg::POS_RIFF: begin
                        if (fs != wavp_pkg::TAG_RIFF) begin
                            err_hit = 1'b1;
                            err_code = wavp_pkg::ERR_RIFF;
                        end
                    end
                    wavp_pkg::POS_WAVE: begin
                        if (fs != wavp_pkg::TAG_WAVE) begin
                            err_hit = 1'b1;
                            err_code = wavp_pkg::ERR_WAVE;
                        end
                    end
                    wavp_pkg::POS_FMT: begin
                        if (fs != wavp_pkg::TAG_FMT) begin
                            err_hit = 1'b1;
                            err_code = wavp_pkg::ERR_FMT;
                        end
                    end
                    wavp_pkg::POS_FORMAT: begin
                        if ((fs & wavp_pkg::LOW_HALF) != {16'd0, wavp_pkg::FMT_PCM}) begin
                            err_hit = 1'b1;
                            err_code = wavp_pkg::ERR_NOT_PCM;
                        end else if (fs[31:16] != wavp_pkg::CH_MONO &&
                                     fs[31:16] != wavp_pkg::CH_STEREO) begin
                            err_hit = 1'b1;
                            err_code = wavp_pkg::ERR_CHANNELS;
                        end else begin
                            ns.stored_channels = fs[17:16];
                        end
                    end
                    wavp_pkg::POS_RATE: begin
                        ns.stored_rate = fs;
                    end
                    wavp_pkg::POS_DEPTH: begin
                        if (fs[31:16] == wavp_pkg::DEPTH_8) begin
                            err_hit = 1'b1;
                            err_code = wavp_pkg::ERR_8BIT;
                        end else if (fs[31:16] != wavp_pkg::DEPTH_16) begin
                            err_hit = 1'b1;
                            err_code = wavp_pkg::ERR_DEPTH;
                        end
                    end
                    wavp_pkg::POS_DATA_TAG: begin
                        if (fs != wavp_pkg::TAG_DATA) begin
                            err_hit = 1'b1;
                            err_code = wavp_pkg::ERR_DATA_TAG;
                        end
                    end
                    wavp_pkg::POS_LENGTH: begin
                        ns.stored_length = fs;
                        ns.parse_phase = wavp_pkg::PH_DATA;
                        ns.data_bytes_seen = 32'd0;
                        ns.next_channel = 1'b0;
                        res[0].kind = wavp_pkg::KIND_HEADER;
                        res[0].channel_count = s.stored_channels;
                        res[0].sample_rate = s.stored_rate;
                        res[0].data_length = fs;
                        cnt = 2'd1;
                        if (fs == 32'd0) begin
                            res[1].kind = wavp_pkg::KIND_DONE;
                            cnt = 2'd2;
                            ns.parse_phase = wavp_pkg::PH_DONE;
                        end
                    end
                    default: begin
                    end
                endcase
                if (err_hit) begin
                    res[0] = wavp_pkg::error_word(err_code);
                    cnt = 2'd1;
                    ns.parse_phase = wavp_pkg::PH_ERROR;
                end
            end
            wavp_pkg::PH_DATA: begin
                if (!s.data_bytes_seen[0]) begin
                    ns.low_sample_byte = i_word.data_byte;
                end else begin
                    res[0].kind = wavp_pkg::KIND_SAMPLE;
                    res[0].sample_value = $signed({i_word.data_byte, s.low_sample_byte});
                    res[0].channel_index = s.next_channel;
                    cnt = 2'd1;
                    ns.next_channel = (s.stored_channels == 2'd2) ? ~s.next_channel : 1'b0;
                end
                ns.data_bytes_seen = s.data_bytes_seen + 32'd1;
                if (ns.data_bytes_seen == s.stored_length) begin
                    res[cnt[0]].kind = wavp_pkg::KIND_DONE;
                    cnt = cnt + 2'd1;
                    ns.parse_phase = wavp_pkg::PH_DONE;
                end
            end
            default: begin
            end
        endcase

        // stream ran out before header or data finished
        if (!err_hit && i_word.end_of_stream &&
            (ns.parse_phase == wavp_pkg::PH_HEADER || ns.parse_phase == wavp_pkg::PH_DATA)) begin
            res[cnt[0]] = wavp_pkg::error_word(wavp_pkg::ERR_SHORT);
            cnt = cnt + 2'd1;
            ns.parse_phase = wavp_pkg::PH_ERROR;
        end

        if (cnt != 2'd0) begin
            res[cnt[1]].last_result = 1'b1;
        end
    end

    assign o_state   = ns;
    assign o_res[0]  = res[0];
    assign o_res[1]  = res[1];
    assign o_res_cnt = cnt;

endmodule

// ----- rtl/wavp_rfifo.sv -----
module wavp_rfifo #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_push_cnt,
    input  wavp_pkg::t_out_word i_push_data [2],
    input  logic                i_pop,
    output logic                o_room2,
    output logic                o_valid,
    output wavp_pkg::t_out_word o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    wavp_pkg::t_out_word r_mem [DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wptr_p1;
    logic [AW-1:0] n_wptr_p2;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign n_wptr_p1 = ptr_inc(r_wptr);
    assign n_wptr_p2 = ptr_inc(n_wptr_p1);

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wptr] <= i_push_data[0];
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[n_wptr_p1] <= i_push_data[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            case (i_push_cnt)
                2'd1:    r_wptr <= n_wptr_p1;
                2'd2:    r_wptr <= n_wptr_p2;
                default: r_wptr <= r_wptr;
            endcase
            if (i_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            r_count <= r_count + CW'(i_push_cnt) - CW'(i_pop);
        end
    end

    assign o_room2 = (r_count <= CW'(DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];

endmodule

// ----- rtl/wav_pcm16_stream_parser.sv -----
// Channel   Direction  Handshake               Payload
// in        input      i_in_valid/o_in_ready   i_in_data   (wavp_pkg::t_in_word)
// out       output     o_out_valid/i_out_ready o_out_data  (wavp_pkg::t_out_word)
//
// One byte accepted per cycle while o_in_ready is high; its parse runs in the
// cycle it is accepted and its 0 to 2 result words land in the result queue
// the same edge. A result word is offered once the words queued ahead of it
// are taken; the queue drains one word per cycle while i_out_ready is high.
// o_in_ready drops only when the queue lacks room for two words.
// Synchronous active-low reset returns the parser to the header phase and
// empties the queue.
module wav_pcm16_stream_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  wavp_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output wavp_pkg::t_out_word o_out_data
);

    wavp_pkg::t_state    r_state;
    wavp_pkg::t_state    n_state;
    wavp_pkg::t_out_word step_res [2];
    logic [1:0]          step_cnt;
    logic [1:0]          push_cnt;
    logic                in_acc;
    logic                out_acc;
    logic                room2;

    wavp_step u_step (
        .i_state   (r_state),
        .i_word    (i_in_data),
        .o_state   (n_state),
        .o_res     (step_res),
        .o_res_cnt (step_cnt)
    );

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_acc  = o_out_valid && i_out_ready;
    assign push_cnt = in_acc ? step_cnt : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wavp_pkg::STATE_RESET;
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    wavp_rfifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_rfifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_cnt  (push_cnt),
        .i_push_data (step_res),
        .i_pop       (out_acc),
        .o_room2     (room2),
        .o_valid     (o_out_valid),
        .o_data      (o_out_data)
    );

    assign o_in_ready = room2;

    // idle phases swallow bytes until a start flag
    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_in_data.start_of_file &&
        (r_state.parse_phase == wavp_pkg::PH_ERROR ||
         r_state.parse_phase == wavp_pkg::PH_DONE) |-> push_cnt == 2'd0)
        else $error("word emitted while parser idle");

    a_last_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_cnt == 2'd2 |-> !step_res[0].last_result && step_res[1].last_result)
        else $error("last flag misplaced on two-word byte");

    a_chan_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.parse_phase == wavp_pkg::PH_DATA |->
        (r_state.stored_channels == 2'd1 || r_state.stored_channels == 2'd2))
        else $error("data phase with bad channel count");

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == wavp_pkg::KIND_ERROR |->
        o_out_data.error_code <= wavp_pkg::ERR_SHORT)
        else $error("error code out of range");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int          N_ITEMS   = 1800;
    localparam int          LIMIT     = 600000;
    localparam int          TAIL      = 20;
    localparam logic [1:0]  MODE_NONE = 2'd0;
    localparam logic [1:0]  MODE_TX   = 2'd1;
    localparam logic [1:0]  MODE_RX   = 2'd2;
    localparam logic [1:0]  MODE_BOTH = 2'd3;

    typedef struct {
        wavp_pkg::t_in_word w;
        logic [1:0]         mode;
        bit                 hold;
    } t_pending;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    wavp_pkg::t_in_word  in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    wavp_pkg::t_out_word out_data;

    t_pending            pend[$];
    wavp_pkg::t_out_word exp_q[$];
    logic [7:0]          fb[$];
    logic [1:0]          gen_mode = MODE_NONE;
    bit                  gen_hold = 1'b0;
    logic [1:0]          rx_mode = MODE_NONE;
    int                  n_fail = 0;
    int                  cyc = 0;

    // parser shadow state
    logic [5:0]       wp_pos;
    logic [31:0]      wp_seen;
    logic [31:0]      wp_shift;
    logic [1:0]       wp_chans;
    logic [31:0]      wp_rate;
    logic [31:0]      wp_len;
    logic [7:0]       wp_lowb;
    logic             wp_nch;
    wavp_pkg::t_phase wp_phase;

    wav_pcm16_stream_parser DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) cyc <= cyc + 1;

    function automatic wavp_pkg::t_out_word res_word(input logic [1:0] k,
                                                     input logic [15:0] s,
                                                     input logic c, input logic [1:0] cc,
                                                     input logic [31:0] r,
                                                     input logic [31:0] l,
                                                     input logic [3:0] e);
        wavp_pkg::t_out_word o;
        o = '0;
        o.kind          = k;
        o.sample_value  = s;
        o.channel_index = c;
        o.channel_count = cc;
        o.sample_rate   = r;
        o.data_length   = l;
        o.error_code    = e;
        return o;
    endfunction

    task automatic clear_parser();
        wp_pos   = '0;
        wp_seen  = '0;
        wp_shift = '0;
        wp_chans = '0;
        wp_rate  = '0;
        wp_len   = '0;
        wp_lowb  = '0;
        wp_nch   = 1'b0;
        wp_phase = wavp_pkg::PH_HEADER;
    endtask

    task automatic parse_byte(input wavp_pkg::t_in_word w);
        wavp_pkg::t_out_word res [2];
        int                  n;
        logic [5:0]          pos;
        logic [31:0]         wd;
        logic [3:0]          code;
        bit                  fail;
        n = 0;
        fail = 1'b0;
        code = '0;
        if (w.start_of_file) clear_parser();
        if (wp_phase == wavp_pkg::PH_HEADER) begin
            pos = wp_pos;
            wp_shift = {w.data_byte, wp_shift[31:8]};
            wp_pos = pos + 6'd1;
            wd = wp_shift;
            case (pos)
                wavp_pkg::POS_RIFF: begin
                    if (wd != wavp_pkg::TAG_RIFF) begin
                        fail = 1'b1;
                        code = wavp_pkg::ERR_RIFF;
                    end
                end
                wavp_pkg::POS_WAVE: begin
                    if (wd != wavp_pkg::TAG_WAVE) begin
                        fail = 1'b1;
                        code = wavp_pkg::ERR_WAVE;
                    end
                end
                wavp_pkg::POS_FMT: begin
                    if (wd != wavp_pkg::TAG_FMT) begin
                        fail = 1'b1;
                        code = wavp_pkg::ERR_FMT;
                    end
                end
                wavp_pkg::POS_FORMAT: begin
                    if (wd[15:0] != wavp_pkg::FMT_PCM) begin
                        fail = 1'b1;
                        code = wavp_pkg::ERR_NOT_PCM;
                    end else if (wd[31:16] != wavp_pkg::CH_MONO &&
                                 wd[31:16] != wavp_pkg::CH_STEREO) begin
                        fail = 1'b1;
                        code = wavp_pkg::ERR_CHANNELS;
                    end else begin
                        wp_chans = wd[17:16];
                    end
                end
                wavp_pkg::POS_RATE: wp_rate = wd;
                wavp_pkg::POS_DEPTH: begin
                    if (wd[31:16] == wavp_pkg::DEPTH_8) begin
                        fail = 1'b1;
                        code = wavp_pkg::ERR_8BIT;
                    end else if (wd[31:16] != wavp_pkg::DEPTH_16) begin
                        fail = 1'b1;
                        code = wavp_pkg::ERR_DEPTH;
                    end
                end
                wavp_pkg::POS_DATA_TAG: begin
                    if (wd != wavp_pkg::TAG_DATA) begin
                        fail = 1'b1;
                        code = wavp_pkg::ERR_DATA_TAG;
                    end
                end
                wavp_pkg::POS_LENGTH: begin
                    wp_len = wd;
                    res[n] = res_word(wavp_pkg::KIND_HEADER, '0, 1'b0, wp_chans, wp_rate,
                                      wd, '0);
                    n++;
                    wp_phase = wavp_pkg::PH_DATA;
                    wp_seen = '0;
                    wp_nch = 1'b0;
                    if (wd == '0) begin
                        res[n] = res_word(wavp_pkg::KIND_DONE, '0, 1'b0, '0, '0, '0, '0);
                        n++;
                        wp_phase = wavp_pkg::PH_DONE;
                    end
                end
                default: ;
            endcase
            if (fail) begin
                res[n] = res_word(wavp_pkg::KIND_ERROR, '0, 1'b0, '0, '0, '0, code);
                n++;
                wp_phase = wavp_pkg::PH_ERROR;
            end
        end else if (wp_phase == wavp_pkg::PH_DATA) begin
            if (!wp_seen[0]) begin
                wp_lowb = w.data_byte;
            end else begin
                res[n] = res_word(wavp_pkg::KIND_SAMPLE, {w.data_byte, wp_lowb}, wp_nch,
                                  '0, '0, '0, '0);
                n++;
                wp_nch = (wp_chans == 2'd2) ? ~wp_nch : 1'b0;
            end
            wp_seen = wp_seen + 32'd1;
            if (wp_seen == wp_len) begin
                res[n] = res_word(wavp_pkg::KIND_DONE, '0, 1'b0, '0, '0, '0, '0);
                n++;
                wp_phase = wavp_pkg::PH_DONE;
            end
        end
        if (!fail && w.end_of_stream &&
            (wp_phase == wavp_pkg::PH_HEADER || wp_phase == wavp_pkg::PH_DATA)) begin
            res[n] = res_word(wavp_pkg::KIND_ERROR, '0, 1'b0, '0, '0, '0,
                              wavp_pkg::ERR_SHORT);
            n++;
            wp_phase = wavp_pkg::PH_ERROR;
        end
        if (n > 0) res[n-1].last_result = 1'b1;
        for (int i = 0; i < n; i++) exp_q.push_back(res[i]);
    endtask

    task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
        if (e !== a) begin
            $error("%s mismatch: expected %0h, actual %0h", name, e, a);
            n_fail++;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end else begin
            if (in_valid && in_ready) parse_byte(in_data);
            if (!in_valid || in_ready) begin
                if (pend.size() != 0 && !(pend[0].hold && exp_q.size() != 0) &&
                    !((pend[0].mode == MODE_TX && $urandom_range(99) < 78) ||
                      (pend[0].mode == MODE_BOTH && $urandom_range(99) < 7))) begin
                    in_data  <= pend[0].w;
                    in_valid <= 1'b1;
                    rx_mode  <= pend[0].mode;
                    void'(pend.pop_front());
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (exp_q.size() == 0) begin
                    $error("unexpected result word: kind %0d", out_data.kind);
                    n_fail++;
                end else begin
                    check_field("kind", 32'(exp_q[0].kind), 32'(out_data.kind));
                    check_field("sample_value", 32'(exp_q[0].sample_value),
                                32'(out_data.sample_value));
                    check_field("channel_index", 32'(exp_q[0].channel_index),
                                32'(out_data.channel_index));
                    check_field("channel_count", 32'(exp_q[0].channel_count),
                                32'(out_data.channel_count));
                    check_field("sample_rate", exp_q[0].sample_rate, out_data.sample_rate);
                    check_field("data_length", exp_q[0].data_length, out_data.data_length);
                    check_field("error_code", 32'(exp_q[0].error_code),
                                32'(out_data.error_code));
                    check_field("last_result", 32'(exp_q[0].last_result),
                                32'(out_data.last_result));
                    void'(exp_q.pop_front());
                end
            end
            out_ready <= !((rx_mode == MODE_RX && $urandom_range(99) < 78) ||
                           (rx_mode == MODE_BOTH && $urandom_range(99) < 7));
        end
    end

    task automatic push_byte(input logic [7:0] b, input bit sof, input bit eos);
        t_pending p;
        p.w.data_byte     = b;
        p.w.start_of_file = sof;
        p.w.end_of_stream = eos;
        p.mode = gen_mode;
        p.hold = gen_hold;
        gen_hold = 1'b0;
        pend.push_back(p);
    endtask

    task automatic put_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) fb.push_back(w[8*i +: 8]);
    endtask

    task automatic build_file(input logic [15:0] chans, input logic [15:0] fmt,
                              input logic [31:0] rate, input logic [15:0] depth,
                              input logic [31:0] len, input int ndata);
        fb.delete();
        put_word(wavp_pkg::TAG_RIFF);
        put_word($urandom);
        put_word(wavp_pkg::TAG_WAVE);
        put_word(wavp_pkg::TAG_FMT);
        put_word($urandom);
        put_word({chans, fmt});
        put_word(rate);
        put_word($urandom);
        put_word({depth, 16'($urandom)});
        put_word(wavp_pkg::TAG_DATA);
        put_word(len);
        repeat (ndata) fb.push_back(8'($urandom));
    endtask

    task automatic send_bytes(input int lo, input int hi, input bit sof, input bit eos);
        for (int i = lo; i <= hi; i++) push_byte(fb[i], sof && i == lo, eos && i == hi);
    endtask

    task automatic send_all(input bit sof, input bit eos);
        send_bytes(0, fb.size() - 1, sof, eos);
    endtask

    task automatic directed_files();
        // bytes before any start, extreme sample values, mono
        build_file(wavp_pkg::CH_MONO, wavp_pkg::FMT_PCM, 32'd44100, wavp_pkg::DEPTH_16,
                   32'd8, 8);
        fb[44] = 8'h00; fb[45] = 8'h80; fb[46] = 8'hff; fb[47] = 8'h7f;
        fb[48] = 8'h00; fb[49] = 8'h00; fb[50] = 8'hff; fb[51] = 8'hff;
        send_all(1'b0, 1'b0);
        // stereo, odd length, end flag on the final byte
        build_file(wavp_pkg::CH_STEREO, wavp_pkg::FMT_PCM, 32'hffff_ffff,
                   wavp_pkg::DEPTH_16, 32'd9, 9);
        send_all(1'b1, 1'b1);
        // zero length with end flag on the length byte
        build_file(wavp_pkg::CH_MONO, wavp_pkg::FMT_PCM, 32'd0, wavp_pkg::DEPTH_16, 32'd0, 0);
        send_all(1'b1, 1'b1);
        // header check failures, trailing bytes ignored
        build_file(wavp_pkg::CH_STEREO, wavp_pkg::FMT_PCM, $urandom, wavp_pkg::DEPTH_16,
                   32'd4, 4);
        fb[1] = fb[1] ^ 8'h01;
        send_all(1'b1, 1'b0);
        build_file(wavp_pkg::CH_STEREO, wavp_pkg::FMT_PCM, $urandom, wavp_pkg::DEPTH_16,
                   32'd4, 4);
        fb[10] = fb[10] ^ 8'h80;
        send_all(1'b1, 1'b0);
        build_file(wavp_pkg::CH_STEREO, wavp_pkg::FMT_PCM, $urandom, wavp_pkg::DEPTH_16,
                   32'd4, 4);
        fb[15] = fb[15] ^ 8'h01;
        send_all(1'b1, 1'b0);
        build_file(16'd3, 16'hfffe, $urandom, wavp_pkg::DEPTH_16, 32'd2, 2);
        send_all(1'b1, 1'b0);
        build_file(16'd0, wavp_pkg::FMT_PCM, $urandom, wavp_pkg::DEPTH_16, 32'd2, 2);
        send_all(1'b1, 1'b0);
        build_file(16'hffff, wavp_pkg::FMT_PCM, $urandom, wavp_pkg::DEPTH_16, 32'd2, 2);
        send_all(1'b1, 1'b0);
        build_file(wavp_pkg::CH_MONO, wavp_pkg::FMT_PCM, $urandom, wavp_pkg::DEPTH_8,
                   32'd2, 2);
        send_all(1'b1, 1'b0);
        build_file(wavp_pkg::CH_MONO, wavp_pkg::FMT_PCM, $urandom, 16'hffff, 32'd2, 2);
        send_all(1'b1, 1'b0);
        build_file(wavp_pkg::CH_MONO, wavp_pkg::FMT_PCM, $urandom, wavp_pkg::DEPTH_16,
                   32'd2, 2);
        fb[39] = fb[39] ^ 8'h40;
        send_all(1'b1, 1'b0);
        // failing check and end flag on the same byte
        build_file(wavp_pkg::CH_MONO, wavp_pkg::FMT_PCM, $urandom, wavp_pkg::DEPTH_16,
                   32'd2, 2);
        fb[3] = 8'h00;
        send_bytes(0, 3, 1'b1, 1'b1);
        // early end inside the header
        build_file(wavp_pkg::CH_STEREO, wavp_pkg::FMT_PCM, $urandom, wavp_pkg::DEPTH_16,
                   32'd2, 2);
        send_bytes(0, 20, 1'b1, 1'b1);
        // early end inside the data, on a sample byte
        build_file(wavp_pkg::CH_STEREO, wavp_pkg::FMT_PCM, $urandom, wavp_pkg::DEPTH_16,
                   32'hffff_ffff, 6);
        send_bytes(0, 49, 1'b1, 1'b1);
        // restart in the middle of the data
        build_file(wavp_pkg::CH_STEREO, wavp_pkg::FMT_PCM, $urandom, wavp_pkg::DEPTH_16,
                   32'd20, 20);
        send_bytes(0, 53, 1'b1, 1'b0);
        // bytes after done are ignored
        build_file(wavp_pkg::CH_STEREO, wavp_pkg::FMT_PCM, $urandom, wavp_pkg::DEPTH_16,
                   32'd2, 5);
        send_all(1'b1, 1'b0);
    endtask

    task automatic random_file();
        int unsigned r;
        int unsigned len;
        int unsigned k;
        logic [15:0] chans;
        r = $urandom_range(99);
        len = ($urandom_range(19) == 0) ? $urandom_range(200, 25) : $urandom_range(24);
        chans = 16'($urandom_range(2, 1));
        if ($urandom_range(19) == 0) gen_hold = 1'b1;
        if (r < 60) begin
            build_file(chans, wavp_pkg::FMT_PCM, $urandom, wavp_pkg::DEPTH_16, len,
                       int'(len + (($urandom_range(3) == 0) ? $urandom_range(3) : 0)));
            send_all($urandom_range(19) != 0, $urandom_range(9) < 3);
        end else if (r < 72) begin
            build_file(chans, wavp_pkg::FMT_PCM, $urandom, wavp_pkg::DEPTH_16, len, int'(len));
            send_bytes(0, int'($urandom_range(fb.size() - 1)), 1'b1, 1'($urandom_range(1)));
        end else if (r < 85) begin
            build_file(chans, wavp_pkg::FMT_PCM, $urandom, wavp_pkg::DEPTH_16, len, int'(len));
            k = $urandom_range(43);
            if ($urandom_range(1)) fb[k] = 8'($urandom);
            else fb[k] = fb[k] ^ (8'h01 << $urandom_range(7));
            send_all(1'b1, 1'($urandom_range(1)));
        end else if (r < 92) begin
            case ($urandom_range(2))
                0: build_file(16'($urandom), wavp_pkg::FMT_PCM, $urandom, wavp_pkg::DEPTH_16,
                              len, int'(len));
                1: build_file(chans, 16'($urandom), $urandom, wavp_pkg::DEPTH_16, len,
                              int'(len));
                default: build_file(chans, wavp_pkg::FMT_PCM, $urandom,
                                    $urandom_range(1) ? wavp_pkg::DEPTH_8 : 16'($urandom),
                                    len, int'(len));
            endcase
            send_all(1'b1, 1'($urandom_range(1)));
        end else begin
            repeat ($urandom_range(8, 1))
                push_byte(8'($urandom), $urandom_range(9) == 0, $urandom_range(9) == 0);
        end
    endtask

    initial begin
        int n_dir;
        clear_parser();
        gen_mode = MODE_NONE;
        directed_files();
        n_dir = pend.size();
        gen_hold = 1'b1;
        while (pend.size() < N_ITEMS) begin
            case ((pend.size() - n_dir) * 4 / (N_ITEMS - n_dir))
                0: gen_mode = MODE_NONE;
                1: gen_mode = MODE_TX;
                2: gen_mode = MODE_RX;
                default: gen_mode = MODE_BOTH;
            endcase
            random_file();
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while ((pend.size() != 0 || in_valid || exp_q.size() != 0) && cyc < LIMIT)
            @(posedge i_clk);
        if (cyc >= LIMIT) begin
            $display("TB_ERROR");
        end else begin
            repeat (TAIL) @(posedge i_clk);
            if (exp_q.size() != 0) begin
                $error("%0d expected result words never arrived", exp_q.size());
                n_fail++;
            end
            if (n_fail == 0) begin
                $display("TB_OK");
            end else begin
                $display("TB_ERROR");
            end
        end
        $finish;
    end

endmodule
